>>> rtl/core/prap_pkg.sv
// shared types, constants and tables for the point rotation block
package prap_pkg;

   localparam int STEP_W        = 5;
   localparam int JOINT_SLOTS   = 8;
   localparam int REDUCE_STEPS  = 6;
   localparam int ZW            = 34;

   localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [ZW-1:0] TWO_PI_Q30  = 34'sd6746518852;
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [ZW-1:0] GAIN_Q30    = 34'sd652032874;
   localparam logic [38:0]          TWO_PI_RED  = 39'd6746518852;
   localparam logic signed [65:0]   ROUND_Q29   = 66'sd268435456;

   typedef struct packed {
      logic              load;
      logic              limit;
      logic              reduce;
      logic              fold;
      logic              prep;
      logic              rotate;
      logic              scale;
      logic              mul0;
      logic              mul1;
      logic              mul2;
      logic              finish;
      logic [STEP_W-1:0] step;
   } prap_cmd_type;

   typedef struct packed {
      logic out_free;
   } prap_status_type;

   function automatic logic [31:0] atan_q30(input logic [STEP_W-1:0] i);
      case (i)
         5'd0:    return 32'd843314857;
         5'd1:    return 32'd497837829;
         5'd2:    return 32'd263043837;
         5'd3:    return 32'd133525159;
         5'd4:    return 32'd67021687;
         5'd5:    return 32'd33543516;
         5'd6:    return 32'd16775851;
         5'd7:    return 32'd8388437;
         5'd8:    return 32'd4194283;
         5'd9:    return 32'd2097149;
         5'd10:   return 32'd1048576;
         5'd11:   return 32'd524288;
         5'd12:   return 32'd262144;
         5'd13:   return 32'd131072;
         5'd14:   return 32'd65536;
         5'd15:   return 32'd32768;
         5'd16:   return 32'd16384;
         5'd17:   return 32'd8192;
         5'd18:   return 32'd4096;
         5'd19:   return 32'd2048;
         5'd20:   return 32'd1024;
         5'd21:   return 32'd512;
         5'd22:   return 32'd256;
         5'd23:   return 32'd128;
         5'd24:   return 32'd64;
         5'd25:   return 32'd32;
         5'd26:   return 32'd16;
         5'd27:   return 32'd8;
         5'd28:   return 32'd4;
         5'd29:   return 32'd2;
         default: return 32'd0;
      endcase
   endfunction

   // two pi scaled by 32, 16, ... 1 for the remainder steps
   function automatic logic [38:0] reduce_divisor(input logic [STEP_W-1:0] i);
      case (i)
         5'd0:    return TWO_PI_RED << 5;
         5'd1:    return TWO_PI_RED << 4;
         5'd2:    return TWO_PI_RED << 3;
         5'd3:    return TWO_PI_RED << 2;
         5'd4:    return TWO_PI_RED << 1;
         default: return TWO_PI_RED;
      endcase
   endfunction

endpackage

>>> rtl/core/point_rotate_about_pivot_top.sv
// top level of the point rotation about a pivot block
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  point, pivot, angle, flags, joint
//   rsp_      out        rsp_valid / rsp_stall  rotated point, clamp, group end
//   csr_      in         csr_valid / csr_ready  max_rotation
//
// one item at a time; the input closes on a transfer and opens again in the same
// cycle that the result appears, once the six remainder steps and the iterative
// cordic loop have run.
// the finished result sits in an output register, so a stalled rsp_ only holds
// the block once the next result is ready. synchronous reset clears the joint
// accumulators and loads max_rotation with its default.
module point_rotate_about_pivot_top
   import prap_pkg::*;
#(
   parameter int JOINT_COUNT  = 8,
   parameter int CORDIC_STEPS = 18
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_pivot_x,
   input  logic signed [31:0] req_pivot_y,
   input  logic signed [23:0] req_angle,
   input  logic               req_clockwise,
   input  logic               req_use_limit,
   input  logic [2:0]         req_joint_index,
   input  logic               req_last_point,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_rotated_x,
   output logic signed [31:0] rsp_rotated_y,
   output logic               rsp_was_clamped,
   output logic               rsp_group_end,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic signed [23:0] csr_max_rotation
);

   prap_cmd_type    cmd;
   prap_status_type status;

   assign csr_ready = 1'b1;

   prap_ctrl #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   prap_dp #(
      .JOINT_COUNT (JOINT_COUNT)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_pivot_x      (req_pivot_x),
      .req_pivot_y      (req_pivot_y),
      .req_angle        (req_angle),
      .req_clockwise    (req_clockwise),
      .req_use_limit    (req_use_limit),
      .req_joint_index  (req_joint_index),
      .req_last_point   (req_last_point),
      .csr_valid        (csr_valid && csr_ready),
      .csr_max_rotation (csr_max_rotation),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_rotated_x    (rsp_rotated_x),
      .rsp_rotated_y    (rsp_rotated_y),
      .rsp_was_clamped  (rsp_was_clamped),
      .rsp_group_end    (rsp_group_end)
   );

   // a transfer in closes the input until the item is done
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input open right after a transfer");

   // a new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid || !rsp_stall))
      else $error("result register overwritten while stalled");

   // a result only appears from a finished item
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.finish))
      else $error("result valid without a finished item");

   // no new item while the datapath is mid-computation
   a_load_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !req_stall)
      else $error("item loaded while busy");

endmodule

>>> rtl/core/prap_ctrl.sv
// sequencer for the point rotation datapath
module prap_ctrl
   import prap_pkg::*;
#(
   parameter int CORDIC_STEPS = 18
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  prap_status_type status,
   output prap_cmd_type    cmd
);

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_LIMIT  = 10'b0000000010,
      ST_REDUCE = 10'b0000000100,
      ST_FOLD   = 10'b0000001000,
      ST_PREP   = 10'b0000010000,
      ST_ROTATE = 10'b0000100000,
      ST_SCALE  = 10'b0001000000,
      ST_MUL0   = 10'b0010000000,
      ST_MUL1   = 10'b0100000000,
      ST_MUL2   = 10'b1000000000
   } prap_state_type;

   localparam logic [STEP_W-1:0] LAST_ROT = STEP_W'(CORDIC_STEPS - 1);
   localparam logic [STEP_W-1:0] LAST_RED = STEP_W'(REDUCE_STEPS - 1);

   prap_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              done_ff, done_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      done_in  = done_ff;
      cmd      = '0;
      cmd.step = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_LIMIT;
            end
         end
         ST_LIMIT: begin
            cmd.limit = 1'b1;
            step_in   = '0;
            state_in  = ST_REDUCE;
         end
         ST_REDUCE: begin
            cmd.reduce = 1'b1;
            step_in    = step_ff + 1'b1;
            if (step_ff == LAST_RED) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            state_in = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            step_in  = '0;
            state_in = ST_ROTATE;
         end
         ST_ROTATE: begin
            cmd.rotate = 1'b1;
            step_in    = step_ff + 1'b1;
            if (step_ff == LAST_ROT) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_MUL0;
         end
         ST_MUL0: begin
            cmd.mul0 = 1'b1;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            // sums are held until the result register frees up
            if (!done_ff) begin
               cmd.mul2 = 1'b1;
               done_in  = 1'b1;
            end else if (status.out_free) begin
               cmd.finish = 1'b1;
               done_in    = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         done_ff  <= done_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

>>> rtl/core/prap_dp.sv
// datapath: joint limit, angle reduction, cordic and pivot rotation
module prap_dp
   import prap_pkg::*;
#(
   parameter int JOINT_COUNT = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  prap_cmd_type       cmd,
   output prap_status_type    status,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_pivot_x,
   input  logic signed [31:0] req_pivot_y,
   input  logic signed [23:0] req_angle,
   input  logic               req_clockwise,
   input  logic               req_use_limit,
   input  logic [2:0]         req_joint_index,
   input  logic               req_last_point,
   input  logic               csr_valid,
   input  logic signed [23:0] csr_max_rotation,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_rotated_x,
   output logic signed [31:0] rsp_rotated_y,
   output logic               rsp_was_clamped,
   output logic               rsp_group_end
);

   localparam int STORE_DEPTH = (JOINT_COUNT < JOINT_SLOTS) ? JOINT_COUNT : JOINT_SLOTS;
   localparam int JW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
      if (v > 38'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -38'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   logic signed [32:0]    dx_ff, dy_ff;
   logic signed [31:0]    cx_ff, cy_ff;
   logic signed [23:0]    ang_ff;
   logic                  cw_ff, lim_ff, last_ff;
   logic [2:0]            jdx_ff;
   logic                  clamp_ff, clamp_in;
   logic                  neg_ff, neg_in;
   logic [38:0]           rem_ff, rem_in;
   logic signed [ZW-1:0]  z_ff, z_in;
   logic                  flip_ff, flip_in;
   logic signed [ZW-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [31:0]    c_ff, c_in, s_ff, s_in;
   logic signed [64:0]    p1_ff, p2_ff, sx_ff, sy_ff;
   logic signed [65:0]    sumx_ff, sumx_in, sumy_ff, sumy_in;
   logic signed [23:0]    joint_ff [STORE_DEPTH];
   logic signed [23:0]    max_ff;
   logic signed [31:0]    rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic                  rsp_clamp_ff, rsp_end_ff, rsp_valid_ff, rsp_valid_in;

   // limit and accumulator
   logic                  jvalid;
   logic [JW-1:0]         jidx;
   logic signed [23:0]    cur;
   logic signed [24:0]    sum_req, ang_eff;
   logic signed [25:0]    acc_sum;
   logic signed [23:0]    acc_sat;
   logic [24:0]           mag;
   logic                  joint_we;

   always_comb begin
      jvalid   = (32'(jdx_ff) < JOINT_COUNT);
      jidx     = JW'(jdx_ff);
      cur      = jvalid ? joint_ff[jidx] : 24'sd0;
      sum_req  = 25'(cur) + 25'(ang_ff);
      clamp_in = lim_ff && !cw_ff && (sum_req > 25'(max_ff));
      if (clamp_in) begin
         ang_eff = 25'(max_ff) - 25'(cur);
      end else if (cw_ff) begin
         ang_eff = -25'(ang_ff);
      end else begin
         ang_eff = 25'(ang_ff);
      end
      acc_sum = 26'(cur) + 26'(ang_eff);
      if (acc_sum > 26'sd8388607) begin
         acc_sat = 24'sh7fffff;
      end else if (acc_sum < -26'sd8388608) begin
         acc_sat = 24'sh800000;
      end else begin
         acc_sat = acc_sum[23:0];
      end
      joint_we = cmd.limit && lim_ff && last_ff && jvalid;
      neg_in   = ang_eff[24];
      mag      = neg_in ? 25'(-ang_eff) : 25'(ang_eff);
   end

   // angle reduction, fold and cordic
   logic [38:0]          red_div;
   logic signed [ZW-1:0] r_s, w_s, x_sh, y_sh, atan_s, xf, yf;
   logic signed [ZW:0]   c_wide, s_wide;

   always_comb begin
      rem_in  = rem_ff;
      z_in    = z_ff;
      flip_in = flip_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      c_in    = c_ff;
      s_in    = s_ff;
      red_div = reduce_divisor(cmd.step);
      r_s     = $signed({1'b0, rem_ff[ZW-2:0]});
      w_s     = (r_s > PI_Q30) ? (r_s - TWO_PI_Q30) : r_s;
      x_sh    = x_ff >>> cmd.step;
      y_sh    = y_ff >>> cmd.step;
      atan_s  = $signed({2'b00, atan_q30(cmd.step)});
      xf      = flip_ff ? -x_ff : x_ff;
      yf      = flip_ff ? -y_ff : y_ff;
      c_wide  = (35'(xf) + 35'sd1) >>> 1;
      s_wide  = (35'(yf) + 35'sd1) >>> 1;
      if (cmd.limit) begin
         rem_in = {mag, 14'd0};
      end
      if (cmd.reduce && (rem_ff >= red_div)) begin
         rem_in = rem_ff - red_div;
      end
      if (cmd.fold) begin
         z_in = neg_ff ? -w_s : w_s;
      end
      if (cmd.prep) begin
         x_in    = GAIN_Q30;
         y_in    = '0;
         flip_in = 1'b0;
         if (z_ff > HALF_PI_Q30) begin
            z_in    = z_ff - PI_Q30;
            flip_in = 1'b1;
         end else if (z_ff < -HALF_PI_Q30) begin
            z_in    = z_ff + PI_Q30;
            flip_in = 1'b1;
         end
      end
      if (cmd.rotate) begin
         if (!z_ff[ZW-1]) begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - atan_s;
         end else begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + atan_s;
         end
      end
      if (cmd.scale) begin
         c_in = c_wide[31:0];
         s_in = s_wide[31:0];
      end
   end

   // shared multiplier pair, used in the mul0 and mul1 steps
   logic signed [31:0] mul_a, mul_c;
   logic signed [32:0] mul_b;
   logic signed [64:0] prod1, prod2;

   assign mul_a = cmd.mul0 ? c_ff : s_ff;
   assign mul_c = cmd.mul0 ? s_ff : c_ff;
   assign mul_b = cmd.mul0 ? dx_ff : dy_ff;
   assign prod1 = mul_a * mul_b;
   assign prod2 = mul_c * mul_b;

   assign sumx_in = cmd.mul2 ? (66'(sx_ff) - 66'(p1_ff) + ROUND_Q29) : sumx_ff;
   assign sumy_in = cmd.mul2 ? (66'(sy_ff) + 66'(p2_ff) + ROUND_Q29) : sumy_ff;

   // pivot add and saturation
   logic signed [36:0] qx, qy;

   always_comb begin
      qx           = sumx_ff[65:29];
      qy           = sumy_ff[65:29];
      rsp_x_in     = sat32(38'(qx) + 38'(cx_ff));
      rsp_y_in     = sat32(38'(qy) + 38'(cy_ff));
      status.out_free = !rsp_valid_ff || !rsp_stall;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dx_ff   <= 33'(req_point_x) - 33'(req_pivot_x);
         dy_ff   <= 33'(req_point_y) - 33'(req_pivot_y);
         cx_ff   <= req_pivot_x;
         cy_ff   <= req_pivot_y;
         ang_ff  <= req_angle;
         cw_ff   <= req_clockwise;
         lim_ff  <= req_use_limit;
         jdx_ff  <= req_joint_index;
         last_ff <= req_last_point;
      end
      if (cmd.limit) begin
         clamp_ff <= clamp_in;
         neg_ff   <= neg_in;
      end
      rem_ff  <= rem_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      c_ff    <= c_in;
      s_ff    <= s_in;
      if (cmd.mul0 || cmd.mul1) begin
         p1_ff <= prod1;
         p2_ff <= prod2;
      end
      if (cmd.mul1) begin
         sx_ff <= p1_ff;
         sy_ff <= p2_ff;
      end
      sumx_ff <= sumx_in;
      sumy_ff <= sumy_in;
      if (cmd.finish) begin
         rsp_x_ff     <= rsp_x_in;
         rsp_y_ff     <= rsp_y_in;
         rsp_clamp_ff <= clamp_ff;
         rsp_end_ff   <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff       <= 24'sd102944;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < STORE_DEPTH; i++) begin
            joint_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            max_ff <= csr_max_rotation;
         end
         if (joint_we) begin
            joint_ff[jidx] <= acc_sat;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rotated_x   = rsp_x_ff;
   assign rsp_rotated_y   = rsp_y_ff;
   assign rsp_was_clamped = rsp_clamp_ff;
   assign rsp_group_end   = rsp_end_ff;

endmodule

>>> sim/point_rotate_about_pivot_top_tb.sv
`timescale 1ns / 1ps
// testbench for point_rotate_about_pivot_top: random and directed rotations against a predictor
module point_rotate_about_pivot_top_tb;

   localparam int JOINTS = 8;
   localparam int STEPS  = 18;

   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint TWO_PI_Q30  = 64'sd6746518852;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint GAIN_Q30    = 64'sd652032874;
   localparam longint ACC_MAX     = 64'sd8388607;
   localparam longint ACC_MIN     = -64'sd8388608;
   localparam longint COORD_MAX   = 64'sd2147483647;
   localparam longint COORD_MIN   = -64'sd2147483648;

   localparam logic signed [31:0] CMAX    = 32'sh7FFFFFFF;
   localparam logic signed [31:0] CMIN    = 32'sh80000000;
   localparam logic signed [23:0] ANG_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] ANG_MIN = 24'sh800000;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] pivot_x;
      logic signed [31:0] pivot_y;
      logic signed [23:0] angle;
      logic               clockwise;
      logic               use_limit;
      logic [2:0]         joint_index;
      logic               last_point;
   } rotation_req_type;

   typedef struct packed {
      logic signed [31:0] rotated_x;
      logic signed [31:0] rotated_y;
      logic               was_clamped;
      logic               group_end;
   } rotated_point_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_point_x = '0;
   logic signed [31:0] req_point_y = '0;
   logic signed [31:0] req_pivot_x = '0;
   logic signed [31:0] req_pivot_y = '0;
   logic signed [23:0] req_angle = '0;
   logic               req_clockwise = 1'b0;
   logic               req_use_limit = 1'b0;
   logic [2:0]         req_joint_index = '0;
   logic               req_last_point = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_rotated_x;
   logic signed [31:0] rsp_rotated_y;
   logic               rsp_was_clamped;
   logic               rsp_group_end;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic signed [23:0] csr_max_rotation = '0;

   longint atan_q30_table [30] = '{
      843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149,
      1048576, 524288, 262144, 131072, 65536,
      32768, 16384, 8192, 4096, 2048,
      1024, 512, 256, 128, 64,
      32, 16, 8, 4, 2
   };

   logic signed [23:0] joint_rotation [JOINTS];
   logic signed [23:0] max_limit = 24'sd102944;

   rotation_req_type  pending_reqs [$];
   rotated_point_type predicted_points [$];

   int  queued_count = 0;
   int  taken_count = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   int  free_left = 0;
   bit  req_taken = 1'b0;
   bit  quiet = 1'b0;
   bit  mismatch_seen = 1'b0;

   point_rotate_about_pivot_top #(
      .JOINT_COUNT (JOINTS),
      .CORDIC_STEPS(STEPS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_pivot_x     (req_pivot_x),
      .req_pivot_y     (req_pivot_y),
      .req_angle       (req_angle),
      .req_clockwise   (req_clockwise),
      .req_use_limit   (req_use_limit),
      .req_joint_index (req_joint_index),
      .req_last_point  (req_last_point),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_rotated_x   (rsp_rotated_x),
      .rsp_rotated_y   (rsp_rotated_y),
      .rsp_was_clamped (rsp_was_clamped),
      .rsp_group_end   (rsp_group_end),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_max_rotation(csr_max_rotation)
   );

   always #6 clock = ~clock;

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      if (v > hi) begin
         return hi;
      end
      if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

   function automatic void cordic_sin_cos(input longint turn_q16, output longint cos_q29,
                                          output longint sin_q29);
      longint z;
      longint x;
      longint y;
      longint nx;
      bit     flip;
      int     i;
      z = (turn_q16 * 64'sd16384) % TWO_PI_Q30;
      x = GAIN_Q30;
      y = 0;
      flip = 1'b0;
      if (z > PI_Q30) begin
         z -= TWO_PI_Q30;
      end
      if (z < -PI_Q30) begin
         z += TWO_PI_Q30;
      end
      if (z > HALF_PI_Q30) begin
         z -= PI_Q30;
         flip = 1'b1;
      end else if (z < -HALF_PI_Q30) begin
         z += PI_Q30;
         flip = 1'b1;
      end
      for (i = 0; i < STEPS && i < 30; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= atan_q30_table[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += atan_q30_table[i];
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      cos_q29 = (x + 1) >>> 1;
      sin_q29 = (y + 1) >>> 1;
   endfunction

   function automatic rotated_point_type rotate_about_pivot(input rotation_req_type r);
      longint            px;
      longint            py;
      longint            cx;
      longint            cy;
      longint            turn;
      longint            held;
      longint            c;
      longint            s;
      longint            dx;
      longint            dy;
      longint            rx;
      longint            ry;
      longint            acc;
      longint            limit;
      bit                in_range;
      rotated_point_type res;
      px = $signed(r.point_x);
      py = $signed(r.point_y);
      cx = $signed(r.pivot_x);
      cy = $signed(r.pivot_y);
      turn = $signed(r.angle);
      limit = $signed(max_limit);
      in_range = r.joint_index < JOINTS;
      held = 0;
      if (in_range) begin
         held = $signed(joint_rotation[r.joint_index]);
      end
      res.was_clamped = 1'b0;
      if (r.use_limit && !r.clockwise && held + turn > limit) begin
         turn = limit - held;
         res.was_clamped = 1'b1;
      end
      if (r.clockwise) begin
         turn = -turn;
      end
      cordic_sin_cos(turn, c, s);
      dx = px - cx;
      dy = py - cy;
      rx = ((c * dx - s * dy + (64'sd1 <<< 28)) >>> 29) + cx;
      ry = ((s * dx + c * dy + (64'sd1 <<< 28)) >>> 29) + cy;
      if (r.use_limit && r.last_point && in_range) begin
         acc = clip(held + turn, ACC_MIN, ACC_MAX);
         joint_rotation[r.joint_index] = acc[23:0];
      end
      rx = clip(rx, COORD_MIN, COORD_MAX);
      ry = clip(ry, COORD_MIN, COORD_MAX);
      res.rotated_x = rx[31:0];
      res.rotated_y = ry[31:0];
      res.group_end = r.last_point;
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end
      if (r < 90) begin
         return $urandom_range(1, 3);
      end
      if (r < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(30, 80);
   endfunction

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0:       return CMAX;
               1:       return CMIN;
               2:       return '0;
               default: return -32'sd1;
            endcase
         end
         1, 2, 3, 4: return $urandom;
         default:    return int'($urandom_range(0, 33554431)) - 16777216;
      endcase
   endfunction

   function automatic logic signed [23:0] rand_angle();
      logic [31:0] raw;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0:       return ANG_MAX;
               1:       return ANG_MIN;
               2:       return '0;
               default: return -24'sd1;
            endcase
         end
         1, 2, 3: begin
            raw = $urandom;
            return raw[23:0];
         end
         default: return 24'(int'($urandom_range(0, 823550)) - 411775);
      endcase
   endfunction

   function automatic rotation_req_type rand_req();
      rotation_req_type r;
      r.point_x = rand_coord();
      r.point_y = rand_coord();
      r.pivot_x = rand_coord();
      r.pivot_y = rand_coord();
      r.angle = rand_angle();
      r.clockwise = $urandom_range(0, 2) == 0;
      r.use_limit = $urandom_range(0, 1) != 0;
      r.joint_index = 3'($urandom_range(0, 7));
      r.last_point = $urandom_range(0, 2) == 0;
      return r;
   endfunction

   function automatic rotation_req_type make_req(
      input logic signed [31:0] px, input logic signed [31:0] py,
      input logic signed [31:0] cx, input logic signed [31:0] cy,
      input logic signed [23:0] ang, input logic cw, input logic lim,
      input logic [2:0] joint, input logic last);
      rotation_req_type r;
      r.point_x = px;
      r.point_y = py;
      r.pivot_x = cx;
      r.pivot_y = cy;
      r.angle = ang;
      r.clockwise = cw;
      r.use_limit = lim;
      r.joint_index = joint;
      r.last_point = last;
      return r;
   endfunction

   task automatic queue_item(input rotation_req_type r);
      pending_reqs.push_back(r);
      queued_count++;
   endtask

   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (taken_count != queued_count || predicted_points.size() != 0);
   endtask

   task automatic write_max_rotation(input logic signed [23:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_max_rotation <= v;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      max_limit = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // request driver
   always @(negedge clock) begin
      rotation_req_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            next_req = pending_reqs.pop_front();
            req_point_x <= next_req.point_x;
            req_point_y <= next_req.point_y;
            req_pivot_x <= next_req.pivot_x;
            req_pivot_y <= next_req.pivot_y;
            req_angle <= next_req.angle;
            req_clockwise <= next_req.clockwise;
            req_use_limit <= next_req.use_limit;
            req_joint_index <= next_req.joint_index;
            req_last_point <= next_req.last_point;
            req_valid <= 1'b1;
            send_gap = quiet ? 0 : pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (free_left > 0) begin
         rsp_stall <= 1'b0;
         free_left--;
      end else begin
         stall_left = pick_gap();
         free_left = $urandom_range(1, 40);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // transfer monitor and result check
   always @(posedge clock) begin
      rotation_req_type  seen_req;
      rotated_point_type want;
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken) begin
         seen_req.point_x = req_point_x;
         seen_req.point_y = req_point_y;
         seen_req.pivot_x = req_pivot_x;
         seen_req.pivot_y = req_pivot_y;
         seen_req.angle = req_angle;
         seen_req.clockwise = req_clockwise;
         seen_req.use_limit = req_use_limit;
         seen_req.joint_index = req_joint_index;
         seen_req.last_point = req_last_point;
         predicted_points.push_back(rotate_about_pivot(seen_req));
         taken_count++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_points.size() == 0) begin
            $error("rotated point transfer with nothing predicted");
            mismatch_seen = 1'b1;
         end else begin
            want = predicted_points.pop_front();
            if (rsp_rotated_x !== want.rotated_x) begin
               $error("rotated_x expected %0d got %0d", $signed(want.rotated_x),
                      rsp_rotated_x);
               mismatch_seen = 1'b1;
            end
            if (rsp_rotated_y !== want.rotated_y) begin
               $error("rotated_y expected %0d got %0d", $signed(want.rotated_y),
                      rsp_rotated_y);
               mismatch_seen = 1'b1;
            end
            if (rsp_was_clamped !== want.was_clamped) begin
               $error("was_clamped expected %0d got %0d", want.was_clamped,
                      rsp_was_clamped);
               mismatch_seen = 1'b1;
            end
            if (rsp_group_end !== want.group_end) begin
               $error("group_end expected %0d got %0d", want.group_end, rsp_group_end);
               mismatch_seen = 1'b1;
            end
         end
      end
   end

   initial begin
      logic signed [23:0] phase_limits [8];
      rotation_req_type   base;
      rotation_req_type   item;
      int                 phase_items;
      int                 group_len;
      int                 p;
      int                 k;
      foreach (joint_rotation[j]) begin
         joint_rotation[j] = '0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default limit after reset
      queue_item(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0));
      queue_item(make_req(65536, 0, 0, 0, 102944, 0, 0, 0, 1));
      queue_item(make_req(CMAX, CMAX, CMIN, CMIN, 205887, 0, 0, 1, 0));
      queue_item(make_req(CMIN, CMIN, CMAX, CMAX, 0, 0, 0, 2, 1));
      queue_item(make_req(CMAX, CMAX, 0, 0, ANG_MAX, 0, 0, 3, 0));
      queue_item(make_req(-1, -1, 0, 0, ANG_MIN, 0, 0, 4, 1));
      queue_item(make_req(CMIN, CMAX, CMAX, CMIN, 102944, 1, 0, 5, 0));
      queue_item(make_req(CMAX, CMAX, CMAX, CMAX, 102943, 0, 0, 6, 1));
      queue_item(make_req(131072, -65536, 65536, 65536, -102944, 0, 0, 7, 0));
      // clockwise with the most negative angle, accumulator saturates high
      queue_item(make_req(65536, 65536, 0, 0, ANG_MIN, 1, 1, 3, 1));
      queue_item(make_req(65536, 0, 0, 0, 200000, 0, 1, 0, 0));
      queue_item(make_req(65536, 0, 0, 0, 50000, 0, 1, 0, 1));
      queue_item(make_req(65536, 0, 0, 0, 80000, 0, 1, 0, 1));
      // stored rotation already above the limit
      queue_item(make_req(0, 65536, 0, 0, 0, 0, 1, 3, 1));
      queue_item(make_req(65536, 65536, 0, 0, ANG_MAX, 1, 1, 4, 1));
      queue_item(make_req(65536, 65536, 0, 0, ANG_MAX, 1, 1, 4, 1));
      queue_item(make_req(65536, 65536, 0, 0, ANG_MAX, 0, 0, 4, 0));
      queue_item(make_req(-65536, 65536, 0, 0, ANG_MAX, 0, 1, 4, 1));
      wait_idle();

      write_max_rotation(ANG_MIN);
      queue_item(make_req(65536, 65536, 0, 0, 0, 0, 1, 5, 1));
      queue_item(make_req(CMAX, CMIN, 0, 0, ANG_MAX, 0, 1, 6, 0));
      queue_item(make_req(65536, 0, -65536, 0, 1000, 1, 1, 5, 1));
      wait_idle();

      phase_limits = '{ANG_MAX, ANG_MIN, 24'sd0, 24'sd102944, -24'sd1,
                       24'sd205887, 24'sd0, 24'sd0};
      phase_limits[6] = 24'($urandom);
      phase_limits[7] = 24'(int'($urandom_range(0, 823550)) - 411775);
      for (p = 0; p < 8; p++) begin
         write_max_rotation(phase_limits[p]);
         quiet = (p == 2 || p == 5);
         phase_items = 0;
         while (phase_items < 150) begin
            if ($urandom_range(0, 4) == 0) begin
               queue_item(rand_req());
               phase_items++;
            end else begin
               base = rand_req();
               base.use_limit = $urandom_range(0, 3) != 0;
               group_len = $urandom_range(1, 5);
               for (k = 0; k < group_len; k++) begin
                  item = base;
                  item.point_x = rand_coord();
                  item.point_y = rand_coord();
                  item.last_point = (k == group_len - 1);
                  queue_item(item);
               end
               phase_items += group_len;
            end
         end
         wait_idle();
      end

      repeat (40) @(posedge clock);
      if (mismatch_seen || predicted_points.size() != 0) begin
         $display("SCOREBOARD MISMATCH");
      end else begin
         $display("SCOREBOARD CLEAN");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
